// ===== hw/rtl/apnc_pkg.sv =====
// apnc_pkg: shared types, character codes and helper functions for the path checker
`default_nettype none

package apnc_pkg;

   // character codes
   localparam logic [15:0] CH_NUL       = 16'h0000;
   localparam logic [15:0] CH_SPACE     = 16'h0020;
   localparam logic [15:0] CH_QUOTE     = 16'h0022;
   localparam logic [15:0] CH_STAR      = 16'h002A;
   localparam logic [15:0] CH_DOT       = 16'h002E;
   localparam logic [15:0] CH_SLASH     = 16'h002F;
   localparam logic [15:0] CH_ONE       = 16'h0031;
   localparam logic [15:0] CH_NINE      = 16'h0039;
   localparam logic [15:0] CH_COLON     = 16'h003A;
   localparam logic [15:0] CH_LESS      = 16'h003C;
   localparam logic [15:0] CH_GREATER   = 16'h003E;
   localparam logic [15:0] CH_QUESTION  = 16'h003F;
   localparam logic [15:0] CH_UPPER_A   = 16'h0041;
   localparam logic [15:0] CH_UPPER_Z   = 16'h005A;
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_LOWER_A   = 16'h0061;
   localparam logic [15:0] CH_LOWER_Z   = 16'h007A;
   localparam logic [15:0] CH_PIPE      = 16'h007C;
   localparam logic [15:0] CH_SUP_TWO   = 16'h00B2;
   localparam logic [15:0] CH_SUP_THREE = 16'h00B3;
   localparam logic [15:0] CH_SUP_ONE   = 16'h00B9;
   localparam logic [15:0] CTRL_LIMIT   = 16'd32;
   localparam logic [15:0] CASE_OFFSET  = 16'd32;

   // lower-case letters used by the reserved device names
   localparam logic [15:0] CH_A = 16'h0061;
   localparam logic [15:0] CH_C = 16'h0063;
   localparam logic [15:0] CH_L = 16'h006C;
   localparam logic [15:0] CH_M = 16'h006D;
   localparam logic [15:0] CH_N = 16'h006E;
   localparam logic [15:0] CH_O = 16'h006F;
   localparam logic [15:0] CH_P = 16'h0070;
   localparam logic [15:0] CH_R = 16'h0072;
   localparam logic [15:0] CH_T = 16'h0074;
   localparam logic [15:0] CH_U = 16'h0075;
   localparam logic [15:0] CH_X = 16'h0078;

   // counter limits
   localparam logic [2:0] DRIVE_UNITS   = 3'd4;
   localparam logic [2:0] COMP_LEN_MAX  = 3'd5;
   localparam logic [2:0] STEM_MAX      = 3'd4;
   localparam logic [2:0] SHORT_STEM    = 3'd3;
   localparam logic [2:0] POS_LETTER    = 3'd0;
   localparam logic [2:0] POS_COLON     = 3'd1;
   localparam logic [2:0] POS_BACKSLASH = 3'd2;

   // running state of one path
   typedef struct packed {
      logic [2:0]       units_seen;
      logic             failed;
      logic [2:0]       comp_len;
      logic [3:0][15:0] stem_chars;
      logic [2:0]       stem_count;
      logic             stem_hit_dot;
      logic             prev_dot_space;
   } apnc_state_type;

   localparam apnc_state_type STATE_CLEAR = '0;

   // control units and the reserved punctuation
   function automatic logic is_forbidden(input logic [15:0] u);
      return (u < CTRL_LIMIT) || (u == CH_SLASH) || (u == CH_COLON) ||
             (u == CH_LESS) || (u == CH_GREATER) || (u == CH_QUOTE) ||
             (u == CH_PIPE) || (u == CH_QUESTION) || (u == CH_STAR);
   endfunction

   function automatic logic stem_is(input apnc_state_type s, input logic [15:0] a,
                                    input logic [15:0] b, input logic [15:0] c);
      return (s.stem_chars[0] == a) && (s.stem_chars[1] == b) && (s.stem_chars[2] == c);
   endfunction

   // component is empty, ends badly, or names a device
   function automatic logic comp_bad(input apnc_state_type s);
      logic        ended;
      logic        dev3;
      logic        dev4;
      logic        digit;
      logic [15:0] d;
      d     = s.stem_chars[3];
      ended = s.stem_hit_dot || (s.comp_len == s.stem_count);
      dev3  = (s.stem_count == SHORT_STEM) &&
              (stem_is(s, CH_C, CH_O, CH_N) || stem_is(s, CH_P, CH_R, CH_N) ||
               stem_is(s, CH_A, CH_U, CH_X) || stem_is(s, CH_N, CH_U, CH_L));
      digit = ((d >= CH_ONE) && (d <= CH_NINE)) || (d == CH_SUP_ONE) ||
              (d == CH_SUP_TWO) || (d == CH_SUP_THREE);
      dev4  = (s.stem_count == STEM_MAX) && digit &&
              (stem_is(s, CH_C, CH_O, CH_M) || stem_is(s, CH_L, CH_P, CH_T));
      return (s.comp_len == 3'd0) || s.prev_dot_space || (ended && (dev3 || dev4));
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/apnc_step.sv =====
// apnc_step: next-state and verdict logic for one code unit of a path
`default_nettype none

module apnc_step
   import apnc_pkg::*;
(
   input  var apnc_state_type cur_state,
   input  wire logic [15:0]   code_unit,
   input  wire logic          last,
   output apnc_state_type     nxt_state,
   output logic               path_ok
);

   apnc_state_type s;
   logic [15:0]    lower_unit;
   logic           is_letter;

   // fold ascii upper case to lower case
   always_comb begin
      is_letter  = ((code_unit >= CH_UPPER_A) && (code_unit <= CH_UPPER_Z)) ||
                   ((code_unit >= CH_LOWER_A) && (code_unit <= CH_LOWER_Z));
      lower_unit = ((code_unit >= CH_UPPER_A) && (code_unit <= CH_UPPER_Z)) ?
                   code_unit + CASE_OFFSET : code_unit;
   end

   // apply the unit to the running state
   always_comb begin
      s = cur_state;
      if (code_unit == CH_NUL) begin
         s.failed = 1'b1;
      end
      case (cur_state.units_seen)
         POS_LETTER: begin
            if (!is_letter) s.failed = 1'b1;
         end
         POS_COLON: begin
            if (code_unit != CH_COLON) s.failed = 1'b1;
         end
         POS_BACKSLASH: begin
            if (code_unit != CH_BACKSLASH) s.failed = 1'b1;
         end
         default: begin
            if (code_unit == CH_BACKSLASH) begin
               // component closes
               if (comp_bad(cur_state)) s.failed = 1'b1;
               s.comp_len       = 3'd0;
               s.stem_chars     = '0;
               s.stem_count     = 3'd0;
               s.stem_hit_dot   = 1'b0;
               s.prev_dot_space = 1'b0;
            end else begin
               if (is_forbidden(code_unit)) s.failed = 1'b1;
               // stem collection up to the first dot
               if ((cur_state.comp_len == cur_state.stem_count) &&
                   !cur_state.stem_hit_dot) begin
                  if (code_unit == CH_DOT) begin
                     s.stem_hit_dot = 1'b1;
                  end else if (cur_state.stem_count < STEM_MAX) begin
                     s.stem_chars[cur_state.stem_count[1:0]] = lower_unit;
                     s.stem_count = cur_state.stem_count + 3'd1;
                  end
               end
               if (cur_state.comp_len < COMP_LEN_MAX) begin
                  s.comp_len = cur_state.comp_len + 3'd1;
               end
               s.prev_dot_space = (code_unit == CH_DOT) || (code_unit == CH_SPACE);
            end
         end
      endcase
      if (cur_state.units_seen < DRIVE_UNITS) begin
         s.units_seen = cur_state.units_seen + 3'd1;
      end
   end

   // final verdict and return to a fresh path on the last unit
   always_comb begin
      path_ok   = !(s.failed || (s.units_seen < DRIVE_UNITS) || comp_bad(s));
      nxt_state = last ? STATE_CLEAR : s;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/absolute_path_name_checker.sv =====
// absolute_path_name_checker: streaming drive-absolute path validator, top level
// a request is registered, then evaluated; a last request's verdict is
//   registered when the result side is free, and shows on rsp_valid
// throughput: one code unit per cycle while req_stall is low
// reset: synchronous, clears the path state and both valid flags
`default_nettype none

module absolute_path_name_checker
   import apnc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_path_ok
);

   logic           in_valid_ff, in_valid_in;
   logic [15:0]    in_unit_ff;
   logic           in_last_ff;
   apnc_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           out_ok_ff;
   logic           step_ok;
   logic           out_free;
   logic           go;
   logic           req_take;

   // evaluation of the registered request
   apnc_step u_step (
      .cur_state (state_ff),
      .code_unit (in_unit_ff),
      .last      (in_last_ff),
      .nxt_state (state_in),
      .path_ok   (step_ok)
   );

   // handshake: a non-last request never waits on the result side
   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      go           = in_valid_ff && (!in_last_ff || out_free);
      req_stall    = in_valid_ff && !go;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !go);
      out_valid_in = (go && in_last_ff) || (out_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (go) state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_unit_ff <= req_code_unit;
         in_last_ff <= req_last;
      end
      if (go && in_last_ff) begin
         out_ok_ff <= step_ok;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_path_ok = out_ok_ff;

`ifndef SYNTHESIS
   // a path ending leaves the state fresh
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (go && in_last_ff) |=> (state_ff.units_seen == 3'd0 && !state_ff.failed))
      else $error("state not cleared after last request");

   // saturating counters stay in range
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.units_seen <= DRIVE_UNITS) && (state_ff.comp_len <= COMP_LEN_MAX) &&
      (state_ff.stem_count <= STEM_MAX))
      else $error("path counters out of range");

   // no verdict appears from a request that is not last
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && !(go && in_last_ff)) |=> !out_valid_ff)
      else $error("verdict without a last request");

   // stall only with a request held in the input register
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
